### rtl/core/smpc_pkg.sv
// shared types and constants of the soil moisture pump controller
package smpc_pkg;

    localparam int ADC_W   = 12;
    localparam int PCT_W   = 7;
    localparam int SUM_W   = 16;
    localparam int CNT_W   = 4;
    localparam int TICK_W  = 16;
    localparam int CFG_W   = 16;
    localparam int IDX_W   = 3;
    localparam int DVD_W   = 19;
    localparam int DVS_W   = 12;
    localparam int IN_W    = 16;
    localparam int OUT_W   = 24;

    // reciprocal multiply for the group average, exact for any 16-bit sum
    localparam int RCP_SHIFT = 20;
    localparam int RCP_W     = RCP_SHIFT + 1;
    localparam int PROD_W    = SUM_W + RCP_W;

    localparam logic [IDX_W-1:0] CFG_DRY   = 3'd0;
    localparam logic [IDX_W-1:0] CFG_WET   = 3'd1;
    localparam logic [IDX_W-1:0] CFG_START = 3'd2;
    localparam logic [IDX_W-1:0] CFG_STOP  = 3'd3;
    localparam logic [IDX_W-1:0] CFG_TICKS = 3'd4;

    localparam logic [ADC_W-1:0]  DRY_RST   = 12'd2460;
    localparam logic [ADC_W-1:0]  WET_RST   = 12'd1788;
    localparam logic [PCT_W-1:0]  START_RST = 7'd30;
    localparam logic [PCT_W-1:0]  STOP_RST  = 7'd40;
    localparam logic [TICK_W-1:0] TICKS_RST = 16'd2000;

    localparam logic [PCT_W-1:0] PCT_FULL  = 7'd100;
    localparam logic [6:0]       PCT_SCALE = 7'd100;

    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_TICK   = 1'b1;

    typedef struct packed {
        logic accept;
        logic div_pct_start;
        logic load_avg;
        logic load_num;
        logic load_pct;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic need_avg;
        logic div_done;
        logic out_free;
    } t_sts;

endpackage

### rtl/core/smpc_div.sv
// iterative restoring divider, one quotient bit per cycle
module smpc_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [smpc_pkg::DVD_W-1:0]  i_dividend,
    input  logic [smpc_pkg::DVS_W-1:0]  i_divisor,
    output logic                        o_done,
    output logic [smpc_pkg::DVD_W-1:0]  o_quotient
);

    localparam int STEP_W = $clog2(smpc_pkg::DVD_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(smpc_pkg::DVD_W - 1);

    logic                        r_busy;
    logic                        r_done;
    logic [STEP_W-1:0]           r_step;
    logic [smpc_pkg::DVD_W-1:0]  r_quo;
    logic [smpc_pkg::DVS_W-1:0]  r_rem;
    logic [smpc_pkg::DVS_W-1:0]  r_dvs;
    logic [smpc_pkg::DVS_W:0]    w_shift;
    logic                        w_ge;

    assign w_shift = {r_rem, r_quo[smpc_pkg::DVD_W-1]};
    assign w_ge    = w_shift >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_step <= '0;
        end else if (r_busy) begin
            r_step <= r_step + 1'b1;
            if (r_step == LAST_STEP) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[smpc_pkg::DVD_W-2:0], w_ge};
            if (w_ge) begin
                r_rem <= smpc_pkg::DVS_W'(w_shift - {1'b0, r_dvs});
            end else begin
                r_rem <= w_shift[smpc_pkg::DVS_W-1:0];
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

### rtl/core/smpc_datapath.sv
// datapath: config registers, sample accumulator, percent mapping, hysteresis, output register
module smpc_datapath #(
    parameter int SAMPLES = 10
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [smpc_pkg::IDX_W-1:0]  i_cfg_idx,
    input  logic [smpc_pkg::CFG_W-1:0]  i_cfg_data,
    input  logic                        i_req_type,
    input  logic [smpc_pkg::ADC_W-1:0]  i_adc_sample,
    input  logic                        i_m_tready,
    input  smpc_pkg::t_cmd              i_cmd,
    output smpc_pkg::t_sts              o_sts,
    output logic                        o_m_tvalid,
    output logic [smpc_pkg::OUT_W-1:0]  o_m_tdata
);

    localparam logic [smpc_pkg::CNT_W:0]   SAMPLES_CNT = (smpc_pkg::CNT_W+1)'(SAMPLES);
    localparam logic [smpc_pkg::RCP_W-1:0] RCP_MUL =
        smpc_pkg::RCP_W'(((1 << smpc_pkg::RCP_SHIFT) + SAMPLES - 1) / SAMPLES);
    localparam logic [smpc_pkg::DVD_W-1:0] PCT_SCALE_W = smpc_pkg::DVD_W'(smpc_pkg::PCT_SCALE);

    logic [smpc_pkg::ADC_W-1:0]  r_dry;
    logic [smpc_pkg::ADC_W-1:0]  r_wet;
    logic [smpc_pkg::PCT_W-1:0]  r_start;
    logic [smpc_pkg::PCT_W-1:0]  r_stop;
    logic [smpc_pkg::TICK_W-1:0] r_ticks;

    logic [smpc_pkg::SUM_W-1:0]  r_sum;
    logic [smpc_pkg::CNT_W-1:0]  r_cnt;
    logic                        r_trig;
    logic [smpc_pkg::TICK_W-1:0] r_pump;
    logic [smpc_pkg::ADC_W-1:0]  r_avg;
    logic [smpc_pkg::PCT_W-1:0]  r_pct;
    logic                        r_avg_flag;
    logic [smpc_pkg::DVD_W-1:0]  r_num;
    logic                        r_neg;
    logic                        r_out_valid;
    logic [smpc_pkg::OUT_W-1:0]  r_out_data;

    logic [smpc_pkg::CNT_W:0]    w_cnt_inc;
    logic                        w_take;
    logic [smpc_pkg::PROD_W-1:0] w_avg_prod;
    logic                        w_div_done;
    logic [smpc_pkg::DVD_W-1:0]  w_quo;
    logic                        w_span_neg;
    logic [smpc_pkg::ADC_W-1:0]  w_span_mag;
    logic                        w_diff_neg;
    logic [smpc_pkg::ADC_W-1:0]  w_diff_mag;
    logic [smpc_pkg::PCT_W-1:0]  w_pct;
    logic                        w_trig_a;
    logic                        w_out_free;

    assign w_cnt_inc = {1'b0, r_cnt} + 1'b1;
    assign w_take    = (i_req_type == smpc_pkg::REQ_SAMPLE) && (r_pump == '0);

    assign o_sts.need_avg = w_take && (w_cnt_inc >= SAMPLES_CNT);
    assign o_sts.div_done = w_div_done;
    assign w_out_free     = !r_out_valid || i_m_tready;
    assign o_sts.out_free = w_out_free;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dry   <= smpc_pkg::DRY_RST;
            r_wet   <= smpc_pkg::WET_RST;
            r_start <= smpc_pkg::START_RST;
            r_stop  <= smpc_pkg::STOP_RST;
            r_ticks <= smpc_pkg::TICKS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                smpc_pkg::CFG_DRY:   r_dry   <= i_cfg_data[smpc_pkg::ADC_W-1:0];
                smpc_pkg::CFG_WET:   r_wet   <= i_cfg_data[smpc_pkg::ADC_W-1:0];
                smpc_pkg::CFG_START: r_start <= i_cfg_data[smpc_pkg::PCT_W-1:0];
                smpc_pkg::CFG_STOP:  r_stop  <= i_cfg_data[smpc_pkg::PCT_W-1:0];
                smpc_pkg::CFG_TICKS: r_ticks <= i_cfg_data[smpc_pkg::TICK_W-1:0];
                default: ;
            endcase
        end
    end

    // group average by reciprocal multiply
    assign w_avg_prod = r_sum * RCP_MUL;

    // percent divider
    smpc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_pct_start),
        .i_dividend (r_num),
        .i_divisor  (w_span_mag),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    assign w_span_neg = r_wet < r_dry;
    assign w_span_mag = w_span_neg ? (r_dry - r_wet) : (r_wet - r_dry);
    assign w_diff_neg = r_avg < r_dry;
    assign w_diff_mag = w_diff_neg ? (r_dry - r_avg) : (r_avg - r_dry);

    always_comb begin
        priority if (w_span_mag == '0 || r_neg) begin
            w_pct = '0;
        end else if (w_quo > smpc_pkg::DVD_W'(smpc_pkg::PCT_FULL)) begin
            w_pct = smpc_pkg::PCT_FULL;
        end else begin
            w_pct = w_quo[smpc_pkg::PCT_W-1:0];
        end
    end

    assign w_trig_a = r_trig || (w_pct < r_start);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum      <= '0;
            r_cnt      <= '0;
            r_trig     <= 1'b0;
            r_pump     <= '0;
            r_avg      <= '0;
            r_pct      <= '0;
            r_avg_flag <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_avg_flag <= o_sts.need_avg;
                if (i_req_type == smpc_pkg::REQ_TICK) begin
                    if (r_pump != '0) begin
                        r_pump <= r_pump - 1'b1;
                    end
                end else if (w_take) begin
                    r_sum <= r_sum + smpc_pkg::SUM_W'(i_adc_sample);
                    r_cnt <= w_cnt_inc[smpc_pkg::CNT_W-1:0];
                end
            end
            if (i_cmd.load_avg) begin
                r_avg <= w_avg_prod[smpc_pkg::RCP_SHIFT +: smpc_pkg::ADC_W];
                r_sum <= '0;
                r_cnt <= '0;
            end
            if (i_cmd.load_pct) begin
                r_pct <= w_pct;
                if (!r_trig && (w_pct < r_start)) begin
                    r_pump <= r_ticks;
                end
                r_trig <= w_trig_a && !(w_pct > r_stop);
            end
        end
    end

    // scaled numerator magnitude and result sign
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_num) begin
            r_num <= smpc_pkg::DVD_W'(w_diff_mag * PCT_SCALE_W);
            r_neg <= w_diff_neg ^ w_span_neg;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_data <= {2'b00, r_pct, r_avg, r_avg_flag, r_trig, (r_pump != '0)};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

### rtl/core/smpc_ctrl.sv
// controller state machine sequencing one request at a time
module smpc_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    output logic            o_s_tready,
    input  smpc_pkg::t_sts  i_sts,
    output smpc_pkg::t_cmd  o_cmd
);

    typedef enum logic [5:0] {
        ST_IDLE      = 6'b000001,
        ST_AVG       = 6'b000010,
        ST_MAP       = 6'b000100,
        ST_PCT_START = 6'b001000,
        ST_PCT_WAIT  = 6'b010000,
        ST_DONE      = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   w_accept;

    assign o_s_tready = (r_state == ST_IDLE);
    assign w_accept   = o_s_tready && i_s_tvalid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.accept = w_accept;
                if (w_accept) begin
                    n_state = i_sts.need_avg ? ST_AVG : ST_DONE;
                end
            end
            ST_AVG: begin
                o_cmd.load_avg = 1'b1;
                n_state = ST_MAP;
            end
            ST_MAP: begin
                o_cmd.load_num = 1'b1;
                n_state = ST_PCT_START;
            end
            ST_PCT_START: begin
                o_cmd.div_pct_start = 1'b1;
                n_state = ST_PCT_WAIT;
            end
            ST_PCT_WAIT: begin
                if (i_sts.div_done) begin
                    o_cmd.load_pct = 1'b1;
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### rtl/core/soil_moisture_pump_controller.sv
// top level of the soil moisture pump controller
//
// Requests enter on the s_axis channel: tuser is the request type (0 ADC sample,
// 1 millisecond tick), tdata[11:0] the sample. Every request gives exactly one
// result on m_axis, packed from bit 0: pump_drive, trigger_set, average_ready,
// raw_average[11:0], moisture_percent[6:0].
// A tick or a sample that does not close a group goes from accept straight to the
// done state, which loads the result once the output register is free.
// A sample that closes a group of SAMPLES forms the average with a reciprocal
// multiply, then runs the one-bit-a-cycle divider for the percent; the divider
// takes 19 steps, one per quotient bit, before the result is loaded. One request
// is worked on at a time; tready is high only when the controller is idle.
// The result sits in an output register, so the next request is accepted while
// the receiver stalls; a finished second result then waits until the register
// frees up.
// Configuration writes through i_cfg_we/i_cfg_idx/i_cfg_data, only while idle,
// are the user's duty, not enforced. Synchronous reset restores calibration
// defaults and clears sum, count, trigger, pump timer, last average and percent.
module soil_moisture_pump_controller #(
    parameter int SAMPLES = 10
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [smpc_pkg::IDX_W-1:0]  i_cfg_idx,
    input  logic [smpc_pkg::CFG_W-1:0]  i_cfg_data,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [smpc_pkg::IN_W-1:0]   s_axis_tdata,   // adc_sample[11:0]
    input  logic                        s_axis_tuser,   // req_type
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [smpc_pkg::OUT_W-1:0]  m_axis_tdata    // pump_drive, trigger_set,
                                                        // average_ready, raw_average,
                                                        // moisture_percent
);

    smpc_pkg::t_cmd w_cmd;
    smpc_pkg::t_sts w_sts;

    smpc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    smpc_datapath #(
        .SAMPLES (SAMPLES)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_req_type   (s_axis_tuser),
        .i_adc_sample (s_axis_tdata[smpc_pkg::ADC_W-1:0]),
        .i_m_tready   (m_axis_tready),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .o_m_tvalid   (m_axis_tvalid),
        .o_m_tdata    (m_axis_tdata)
    );

endmodule
